// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/fft_pkg.sv -----
// shared types, constants and twiddle table for the radix-2 transform
// no dependencies
`timescale 1ns / 1ps
package fft_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgLog2Points = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgInverseMode = 1'd1;
    localparam int unsigned CfgDataW = 3;

    typedef struct packed {
        logic signed [15:0] coef_real;
        logic signed [15:0] coef_imag;
    } t_coef;

    typedef struct packed {
        logic signed [31:0] point_real;
        logic signed [31:0] point_imag;
        logic [5:0]         point_index;
        logic               point_last;
    } t_point;

    // quarter-wave cosine, round(cos(2 pi k / 64) * 32768)
    function automatic logic signed [17:0] quarter_cos(input logic [4:0] k);
        logic signed [17:0] v;
        case (k)
            5'd0: v = 18'sd32768;   5'd1: v = 18'sd32610;
            5'd2: v = 18'sd32138;   5'd3: v = 18'sd31357;
            5'd4: v = 18'sd30274;   5'd5: v = 18'sd28899;
            5'd6: v = 18'sd27246;   5'd7: v = 18'sd25330;
            5'd8: v = 18'sd23170;   5'd9: v = 18'sd20788;
            5'd10: v = 18'sd18205;  5'd11: v = 18'sd15447;
            5'd12: v = 18'sd12540;  5'd13: v = 18'sd9512;
            5'd14: v = 18'sd6393;   5'd15: v = 18'sd3212;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [17:0] cos64(input logic [5:0] k);
        logic signed [17:0] v;
        if (k <= 6'd16) begin
            v = quarter_cos(k[4:0]);
        end else if (k <= 6'd32) begin
            v = -quarter_cos(5'(6'd32 - k));
        end else if (k <= 6'd48) begin
            v = -quarter_cos(5'(k - 6'd32));
        end else begin
            v = quarter_cos(5'(7'd64 - {1'b0, k}));
        end
        return v;
    endfunction

    function automatic logic signed [17:0] sin64(input logic [5:0] k);
        return cos64(6'(k + 6'd48));
    endfunction
endpackage

// ----- rtl/core/fft_if.sv -----
// valid/ready channel carrying one payload item
// depends on nothing but its type parameter
`timescale 1ns / 1ps
interface fft_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/fft_bfly.sv -----
// shared butterfly unit, two stages: complex product then round and add
// depends on fft_pkg
`timescale 1ns / 1ps
module fft_bfly (
    input  logic               i_clk,
    input  logic signed [31:0] i_er,
    input  logic signed [31:0] i_ei,
    input  logic signed [31:0] i_or,
    input  logic signed [31:0] i_oi,
    input  logic signed [17:0] i_wr,
    input  logic signed [17:0] i_wi,
    output logic signed [31:0] o_er,
    output logic signed [31:0] o_ei,
    output logic signed [31:0] o_or,
    output logic signed [31:0] o_oi
);
    import fft_pkg::*;
    // four 32x18 products, registered before the sum
    logic signed [49:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_er, r_ei;
    logic signed [51:0] s_tr, s_ti;
    logic signed [31:0] s_t_r, s_t_i;

    always_ff @(posedge i_clk) begin
        r_p0 <= 50'(i_or) * 50'(i_wr);
        r_p1 <= 50'(i_oi) * 50'(i_wi);
        r_p2 <= 50'(i_or) * 50'(i_wi);
        r_p3 <= 50'(i_oi) * 50'(i_wr);
        r_er <= i_er;
        r_ei <= i_ei;
    end

    assign s_tr = 52'(r_p0) - 52'(r_p1) + 52'sd16384;
    assign s_ti = 52'(r_p2) + 52'(r_p3) + 52'sd16384;
    assign s_t_r = 32'(s_tr >>> 15);
    assign s_t_i = 32'(s_ti >>> 15);
    assign o_er = r_er + s_t_r;
    assign o_ei = r_ei + s_t_i;
    assign o_or = r_er - s_t_r;
    assign o_oi = r_ei - s_t_i;
endmodule

// ----- rtl/core/radix2_fft.sv -----
// radix-2 decimation-in-time transform, load then compute then emit
// all butterflies run one after another through the one butterfly unit
// each butterfly goes through three steps: memory read, product stage, round/add and write back
// throughput: one load per cycle, then each point is read and then held until taken; no item taken until all N are out
// reset (synchronous, active low) clears the sequencer, load count and registers to
// log2_points 6 and forward mode; the sample memory is not cleared
`timescale 1ns / 1ps
module radix2_fft #(
    parameter int MAX_POINTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fft_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [fft_pkg::CfgDataW-1:0] i_cfg_data,
    fft_if.sink                         s_in,
    fft_if.source                       m_out
);
    import fft_pkg::*;
`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_POINTS);
    // largest size that fits in MAX_POINTS
    localparam int MAXLG = $clog2(MAX_POINTS + 1) - 1;
    localparam int CW = AW + 1;

    // sequencer states
    localparam logic [2:0] StLoad = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StMul  = 3'd2;
    localparam logic [2:0] StWb   = 3'd3;
    localparam logic [2:0] StEmit = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_lg_cfg;
    logic       r_inv;
    logic [CW-1:0] r_cnt;
    logic [2:0] r_stage;     // current stage s, 1..lg
    logic [5:0] r_bf;        // butterfly number in stage
    logic [5:0] r_emit;
    logic [2:0] s_lg;
    logic [6:0] s_n;

    // sample memory
    logic signed [31:0] r_mem_re [MAX_POINTS];
    logic signed [31:0] r_mem_im [MAX_POINTS];
    logic signed [31:0] r_rd_er, r_rd_ei, r_rd_or, r_rd_oi;
    logic signed [17:0] r_wr_, r_wi;
    logic [AW-1:0] r_ea_d, r_oa_d;

    // output item: point read into r_rd_er/r_rd_ei, index and last held here
    t_point s_out;
    logic [5:0] r_out_idx;
    logic   r_out_last;
    logic   r_out_v;

    // active size, saturated to MAX_POINTS
    always_comb begin
        s_lg = r_lg_cfg;
        if (int'(r_lg_cfg) > MAXLG) s_lg = 3'(MAXLG);
    end
    assign s_n = 7'd1 << s_lg;

    // bit reversal of a load position within lg bits
    function automatic logic [5:0] bitrev(input logic [5:0] v, input logic [2:0] lg);
        logic [5:0] r;
        r = '0;
        for (int b = 0; b < 6; b++) begin
            if (b < int'(lg)) r[int'(lg) - 1 - b] = v[b];
        end
        return r;
    endfunction

    // butterfly addressing from stage and count
    logic [6:0] s_half, s_j, s_base;
    logic [5:0] s_e, s_o, s_k;
    always_comb begin
        s_half = 7'd1 << (r_stage - 3'd1);
        s_j = {1'b0, r_bf} & (s_half - 7'd1);
        s_base = ({1'b0, r_bf} - s_j) << 1;
        s_e = 6'(s_base + s_j);
        s_o = 6'(s_base + s_j + s_half);
        s_k = 6'(s_j << (3'd6 - r_stage));
    end

    logic signed [31:0] s_ner, s_nei, s_nor, s_noi;
    fft_bfly u_bfly (
        .i_clk (i_clk),
        .i_er  (r_rd_er), .i_ei (r_rd_ei),
        .i_or  (r_rd_or), .i_oi (r_rd_oi),
        .i_wr  (r_wr_),   .i_wi (r_wi),
        .o_er  (s_ner),   .o_ei (s_nei),
        .o_or  (s_nor),   .o_oi (s_noi)
    );

    logic s_in_acc;
    assign s_in_acc = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == StLoad);
    logic s_load_last;
    assign s_load_last = (7'(r_cnt >= CW'(s_n) ? 7'd0 : 7'(r_cnt)) + 7'd1) >= s_n;
    logic [AW-1:0] s_ld_addr;
    assign s_ld_addr = (7'(r_cnt) >= s_n) ? '0 : r_cnt[AW-1:0];
    logic [5:0] s_ld_rev;
    assign s_ld_rev = bitrev(6'(s_ld_addr), s_lg);
    logic s_last_bf;
    assign s_last_bf = (7'(r_bf) + 7'd1) >= (s_n >> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            StLoad: if (s_in_acc && s_load_last) n_state = (s_lg == 3'd0) ? StEmit : StRead;
            StRead: n_state = StMul;
            StMul:  n_state = StWb;
            StWb: begin
                if (s_last_bf && r_stage == s_lg) n_state = StEmit;
                else n_state = StRead;
            end
            StEmit: n_state = StOut;
            StOut: begin
                if (m_out.ready) n_state = (r_out_last) ? StLoad : StEmit;
            end
            default: n_state = StLoad;
        endcase
    end

    // memory: loads in bit-reversed order, butterfly reads and writes, emit read
    always_ff @(posedge i_clk) begin
        if (r_state == StLoad && s_in_acc) begin
            r_mem_re[s_ld_rev[AW-1:0]] <= 32'(s_in.data.coef_real);
            r_mem_im[s_ld_rev[AW-1:0]] <= 32'(s_in.data.coef_imag);
        end else if (r_state == StWb) begin
            r_mem_re[r_ea_d] <= s_ner;
            r_mem_im[r_ea_d] <= s_nei;
            r_mem_re[r_oa_d] <= s_nor;
            r_mem_im[r_oa_d] <= s_noi;
        end
        if (r_state == StRead) begin
            r_rd_er <= r_mem_re[s_e[AW-1:0]];
            r_rd_ei <= r_mem_im[s_e[AW-1:0]];
            r_rd_or <= r_mem_re[s_o[AW-1:0]];
            r_rd_oi <= r_mem_im[s_o[AW-1:0]];
            r_wr_ <= cos64(s_k);
            r_wi <= r_inv ? -sin64(s_k) : sin64(s_k);
            r_ea_d <= s_e[AW-1:0];
            r_oa_d <= s_o[AW-1:0];
        end
        if (r_state == StEmit) begin
            r_rd_er <= r_mem_re[r_emit[AW-1:0]];
            r_rd_ei <= r_mem_im[r_emit[AW-1:0]];
        end
    end

    // emit path: registered point, inverse scaling on the way out
    logic signed [31:0] s_pr, s_pi;
    logic signed [32:0] s_h;
    always_comb begin
        s_h = 33'(s_n >> 1);
        s_pr = r_rd_er;
        s_pi = r_rd_ei;
        if (r_inv && s_lg != 3'd0) begin
            s_pr = 32'((33'(s_pr) + s_h) >>> s_lg);
            s_pi = 32'((33'(s_pi) + s_h) >>> s_lg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == StEmit) begin
            r_out_idx  <= r_emit;
            r_out_last <= (7'(r_emit) + 7'd1) == s_n;
        end
    end

    always_comb begin
        s_out.point_real  = s_pr;
        s_out.point_imag  = s_pi;
        s_out.point_index = r_out_idx;
        s_out.point_last  = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StLoad;
            r_lg_cfg <= 3'd6;
            r_inv <= 1'b0;
            r_cnt <= '0;
            r_stage <= 3'd1;
            r_bf <= '0;
            r_emit <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == CfgLog2Points) begin
                r_lg_cfg <= i_cfg_data;
                r_cnt <= '0;
            end
            if (i_cfg_we && i_cfg_idx == CfgInverseMode) r_inv <= i_cfg_data[0];
            if (s_in_acc) begin
                r_cnt <= s_load_last ? '0 : CW'({1'b0, s_ld_addr} + 1'b1);
                r_stage <= 3'd1;
                r_bf <= '0;
                r_emit <= '0;
            end
            if (r_state == StWb) begin
                if (s_last_bf) begin
                    r_bf <= '0;
                    r_stage <= r_stage + 3'd1;
                end else begin
                    r_bf <= r_bf + 6'd1;
                end
            end
            if (r_state == StEmit) r_out_v <= 1'b1;
            if (r_state == StOut && m_out.ready) begin
                r_out_v <= 1'b0;
                r_emit <= r_emit + 6'd1;
            end
        end
    end

    assign m_out.valid = r_out_v;
    assign m_out.data  = s_out;

    `ASSERT_IMPL(a_ready_only_load, i_clk, i_rst_n, s_in.ready, r_state == StLoad)
    `ASSERT_IMPL(a_valid_in_out, i_clk, i_rst_n, m_out.valid, r_state == StOut)
    `ASSERT_NEXT(a_last_to_load, i_clk, i_rst_n,
        m_out.valid && m_out.ready && r_out_last, r_state == StLoad)
endmodule

// ----- bench/radix2_fft_tb.sv -----
// self-checking bench for the radix2_fft transform block
// depends on fft_pkg, the fft_if channel interface and the radix2_fft rtl
`timescale 1ns / 1ps
module radix2_fft_tb;
    import fft_pkg::*;

    localparam int CycleLimit = 400000;
    // spare cycles once the last point is out, the block takes items again at the next edge
    localparam int SettleCycles = 700;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    fft_if #(.T(t_coef))  coef_ch ();
    fft_if #(.T(t_point)) point_ch ();

    radix2_fft dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_in       (coef_ch),
        .m_out      (point_ch)
    );

    // coefficients waiting to be offered, points still owed by the block
    t_coef  coef_pending[$];
    t_point points_owed[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_req;
    int unsigned hold_off_left;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    logic        coef_taken;

    // bench copy of the block state: loaded samples, load count and registers
    int          smp_re[64];
    int          smp_im[64];
    int unsigned loaded;
    logic [2:0]  size_log2;
    logic        inv_mode;

    // Q1.15 quarter-wave cosine, 1.0 held exactly as 32768
    function automatic longint cos_q15(input int unsigned k);
        int quarter[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                            23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        k = k % 64;
        if (k <= 16) return quarter[k];
        if (k <= 32) return -quarter[32 - k];
        if (k <= 48) return -quarter[k - 32];
        return quarter[64 - k];
    endfunction

    // load one coefficient; the one that completes the set yields all points
    function automatic void load_coef(input t_coef c);
        int unsigned lg, n, span, half, step, e, o, src;
        longint      wr, wi, tr, ti, pr, pi;
        int          re[64], im[64];
        t_point      p;
        lg = size_log2;
        while (lg > 0 && (1 << lg) > 64) lg--;
        n = 1 << lg;
        if (loaded >= n) loaded = 0;
        smp_re[loaded] = c.coef_real;
        smp_im[loaded] = c.coef_imag;
        loaded++;
        if (loaded < n) return;
        loaded = 0;
        // bit-reversed fetch into working order
        for (int i = 0; i < n; i++) begin
            src = 0;
            for (int b = 0; b < lg; b++) src = (src << 1) | ((i >> b) & 1);
            re[i] = smp_re[src];
            im[i] = smp_im[src];
        end
        for (int s = 1; s <= lg; s++) begin
            span = 1 << s;
            half = span >> 1;
            step = 64 >> s;
            for (int base = 0; base < n; base += span) begin
                for (int j = 0; j < half; j++) begin
                    e = base + j;
                    o = e + half;
                    wr = cos_q15(j * step);
                    wi = cos_q15(j * step + 48);
                    if (inv_mode) wi = -wi;
                    // products rounded to nearest, halves upward
                    tr = (longint'(re[o]) * wr - longint'(im[o]) * wi + 16384) >>> 15;
                    ti = (longint'(re[o]) * wi + longint'(im[o]) * wr + 16384) >>> 15;
                    pr = re[e];
                    pi = im[e];
                    re[e] = int'(pr + tr);
                    im[e] = int'(pi + ti);
                    re[o] = int'(pr - tr);
                    im[o] = int'(pi - ti);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            pr = re[i];
            pi = im[i];
            // inverse divides by n once, rounding shift
            if (inv_mode && lg > 0) begin
                pr = (pr + longint'(n >> 1)) >>> lg;
                pi = (pi + longint'(n >> 1)) >>> lg;
            end
            p.point_real  = pr[31:0];
            p.point_imag  = pi[31:0];
            p.point_index = 6'(i);
            p.point_last  = (i == n - 1);
            points_owed = {points_owed, p};
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sender: a new coefficient only once the previous one has been taken
    always @(negedge clk) begin
        if (!rst_n) begin
            coef_ch.valid <= 1'b0;
            coef_ch.data  <= '0;
        end else if (!coef_ch.valid || coef_taken) begin
            if (coef_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                coef_ch.valid <= 1'b1;
                coef_ch.data  <= coef_pending.pop_front();
            end else begin
                coef_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus the long hold-off when one is requested
    always @(negedge clk) begin
        if (!rst_n) begin
            point_ch.ready <= 1'b0;
            hold_off_left  <= 0;
        end else if (hold_off_left > 0) begin
            point_ch.ready <= 1'b0;
            hold_off_left  <= hold_off_left - 1;
        end else if (hold_off_req > 0) begin
            point_ch.ready <= 1'b0;
            hold_off_left  <= hold_off_req;
        end else begin
            point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: follows register writes, predicts on each accepted coefficient,
    // checks each accepted point
    always @(posedge clk) begin
        t_point want, got;
        coef_taken <= rst_n && coef_ch.valid && coef_ch.ready;
        if (!rst_n) begin
            loaded    = 0;
            size_log2 = 3'd6;
            inv_mode  = 1'b0;
        end else if (cfg_we) begin
            if (cfg_idx == CfgLog2Points) begin
                size_log2 = cfg_data;
                loaded    = 0;
            end else begin
                inv_mode = cfg_data[0];
            end
        end
        if (rst_n && coef_ch.valid && coef_ch.ready) load_coef(coef_ch.data);
        if (rst_n && point_ch.valid && point_ch.ready) begin
            got = point_ch.data;
            if (points_owed.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected point: re %0d im %0d idx %0d last %0b",
                             got.point_real, got.point_imag, got.point_index,
                             got.point_last);
            end else begin
                want = points_owed.pop_front();
                if (got.point_real !== want.point_real
                        || got.point_imag !== want.point_imag
                        || got.point_index !== want.point_index
                        || got.point_last !== want.point_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"point mismatch: expected re %0d im %0d idx %0d last %0b,",
                                  " got re %0d im %0d idx %0d last %0b"},
                                 want.point_real, want.point_imag, want.point_index,
                                 want.point_last, got.point_real, got.point_imag,
                                 got.point_index, got.point_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // register write while no item is in flight; the monitor updates its copy
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CfgDataW'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued coefficient has been taken
    task automatic wait_sent();
        do @(posedge clk); while (coef_pending.size() > 0 || coef_ch.valid);
    endtask

    // wait for all owed points, then for the block to wind down
    task automatic wait_idle();
        wait_sent();
        while (points_owed.size() > 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic push_coef(input int re, input int im);
        t_coef c;
        c.coef_real = 16'(re);
        c.coef_imag = 16'(im);
        coef_pending = {coef_pending, c};
    endtask

    // random content: mostly full range, some small, some at the rails
    task automatic push_random(input int unsigned count);
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(9);
            if (pick < 6)
                push_coef($urandom, $urandom);
            else if (pick < 8)
                push_coef($urandom_range(128) - 64, $urandom_range(128) - 64);
            else
                push_coef($urandom_range(1) ? 32767 : -32768,
                          $urandom_range(1) ? 32767 : -32768);
        end
    endtask

    // one phase: set registers, pick idling, feed whole sets, drain
    task automatic run_phase(input int unsigned lg, input int unsigned inv,
                             input int unsigned sets, input int unsigned snd,
                             input int unsigned rcv);
        int unsigned n;
        n = (lg > 6) ? 64 : (1 << lg);
        write_reg(CfgLog2Points, lg);
        write_reg(CfgInverseMode, inv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        push_random(n * sets);
        wait_idle();
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // single point: values pass straight through, rails included
        write_reg(CfgLog2Points, 0);
        push_coef(-32768, -32768);
        push_coef(32767, 32767);
        push_coef(0, -1);
        wait_idle();
        // two points, inverse, opposite rails
        write_reg(CfgLog2Points, 1);
        write_reg(CfgInverseMode, 1);
        push_coef(32767, -32768);
        push_coef(-32768, 32767);
        wait_idle();
        // partial load thrown away by a size change
        write_reg(CfgInverseMode, 0);
        write_reg(CfgLog2Points, 3);
        push_coef(1000, -1000);
        push_coef(-5, 7);
        push_coef(32767, 32767);
        wait_sent();
        write_reg(CfgLog2Points, 2);
        push_coef(32767, 0);
        push_coef(0, 32767);
        push_coef(-32768, 0);
        push_coef(0, -32768);
        wait_idle();
        // mode flipped half way through a load, taken at compute time
        push_coef(1, -1);
        push_coef(-32768, 32767);
        wait_sent();
        write_reg(CfgInverseMode, 1);
        push_coef(12345, -321);
        push_coef(-1, 1);
        wait_idle();

        // random part over sizes, modes and idling profiles
        run_phase(6, 0, 1, 0, 0);
        run_phase(7, 1, 1, 45, 0);   // oversized setting saturates to 64 points
        run_phase(3, 0, 6, 0, 45);
        run_phase(4, 1, 5, 37, 37);
        run_phase(0, 1, 10, 45, 45);
        run_phase(1, 0, 10, 0, 0);
        run_phase(2, 0, 15, 45, 0);
        run_phase(5, 1, 2, 0, 45);

        // long receiver hold-off while sets keep arriving, block has to back up
        write_reg(CfgLog2Points, 2);
        write_reg(CfgInverseMode, 0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = $urandom_range(400, 250);
        push_random(4 * 8);
        wait (hold_off_left > 0);
        hold_off_req = 0;
        wait_idle();

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- radix2_fft.f -----
+incdir+rtl/core
rtl/core/fft_pkg.sv
rtl/core/fft_if.sv
rtl/core/fft_bfly.sv
rtl/core/radix2_fft.sv
bench/radix2_fft_tb.sv
